@@ design/binco_pkg.sv @@
// ----------------------------------------------------------------------------
// binco_pkg
// Shared widths and limits for the binomial coefficient core and its checker.
// ----------------------------------------------------------------------------
package binco_pkg;

    localparam int N_W    = 6;              // n_total / k_chosen field width
    localparam int COEF_W = 59;             // coefficient field width
    localparam int PROD_W = 64;             // j * C(n, j) for j <= 31, n <= 62
    localparam int J_W    = 5;              // step index, at most 31
    localparam int CNT_W  = $clog2(PROD_W); // bit counter for multiply/divide

    localparam logic [N_W-1:0] MAX_N = N_W'(62);

endpackage

@@ design/binomial_coefficient_core.sv @@
// ----------------------------------------------------------------------------
// binomial_coefficient_core
// Exact C(n, k) through a bit-serial multiply and a restoring divide.
// ----------------------------------------------------------------------------
// Each item computes C(n, k) with k first replaced by min(k, n - k), so at
// most 31 steps run. Step j turns C(n, j-1) into C(n, j) as a 64-bit product
// acc * (n - j + 1), built MSB-first, then divided exactly by j, one
// quotient bit per cycle, and the step is closed in S_STEP. After the last
// step S_FIN loads the result into the output register. k above n, k equal
// to 0 or n give 1; n above 62 gives all ones as an overflow mark. One item
// is worked on at a time; a new item is taken while the previous result
// waits at the output.
// ----------------------------------------------------------------------------
module binomial_coefficient_core
    import binco_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [N_W-1:0]    i_n_total,
    input  logic [N_W-1:0]    i_k_chosen,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COEF_W-1:0] o_coefficient
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_STEP,
        S_FIN
    } t_state;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(N_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    t_state              r_state;
    logic                r_out_valid;
    logic [COEF_W-1:0]   r_coef;
    logic [COEF_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_prod;
    logic [N_W-1:0]      r_mult;
    logic [J_W-1:0]      r_j;
    logic [J_W-1:0]      r_kk;
    logic [J_W-1:0]      r_rem;
    logic [CNT_W-1:0]    r_cnt;

    logic [N_W-1:0]      w_n_minus_k;
    logic [N_W-1:0]      w_kk;
    logic [J_W:0]        w_rem_sh;
    logic [J_W:0]        w_rem_sub;
    logic                w_qbit;
    logic [J_W-1:0]      w_rem_next;
    logic [PROD_W-1:0]   w_addend;

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_coefficient = r_coef;

    // k is only used when k <= n, then min(k, n - k) <= 31
    assign w_n_minus_k = i_n_total - i_k_chosen;
    assign w_kk        = (i_k_chosen > w_n_minus_k) ? w_n_minus_k : i_k_chosen;

    // restoring divide: remainder stays below j
    assign w_rem_sh   = {r_rem, r_prod[PROD_W-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_j};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_j});
    assign w_rem_next = w_qbit ? w_rem_sub[J_W-1:0] : w_rem_sh[J_W-1:0];

    assign w_addend = r_mult[r_cnt[2:0]] ? PROD_W'(r_acc) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mult <= i_n_total;
                        r_j    <= J_W'(1);
                        r_kk   <= w_kk[J_W-1:0];
                        r_acc  <= (i_n_total > MAX_N) ? '1 : COEF_W'(1);
                        r_prod <= '0;
                        r_rem  <= '0;
                        r_cnt  <= MUL_LAST;
                        if (i_n_total > MAX_N) begin
                            r_state <= S_FIN;
                        end else if (i_k_chosen > i_n_total || w_kk == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0} + w_addend;
                    if (r_cnt == '0) begin
                        r_cnt   <= DIV_LAST;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_prod <= {r_prod[PROD_W-2:0], w_qbit};
                    r_rem  <= w_rem_next;
                    if (r_cnt == '0) begin
                        r_state <= S_STEP;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_STEP: begin
                    r_acc <= r_prod[COEF_W-1:0];
                    if (r_j == r_kk) begin
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= r_j + J_W'(1);
                        r_mult  <= r_mult - N_W'(1);
                        r_prod  <= '0;
                        r_cnt   <= MUL_LAST;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_coef      <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/binco_checker.sv @@
// ----------------------------------------------------------------------------
// binco_checker
// Port-level checks for binomial_coefficient_core, bound into every instance of it.
// ----------------------------------------------------------------------------
module binco_checker
    import binco_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [N_W-1:0]    i_n_total,
    input logic [N_W-1:0]    i_k_chosen,
    input logic              o_valid,
    input logic              i_stall,
    input logic [COEF_W-1:0] o_coefficient
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_coefficient))
        else $error("stalled result changed");

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting an item");

    // finishing an item always lands a result in the output register
    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) && $past(i_rst_n) |-> o_valid)
        else $error("item finished without a result");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_coefficient != '0)
        else $error("zero coefficient");

endmodule

bind binomial_coefficient_core binco_checker u_binco_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_n_total     (i_n_total),
    .i_k_chosen    (i_k_chosen),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_coefficient (o_coefficient)
);
